// File: design/atm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the accelerometer trimmed-mean filter.
// Used by atm_cell, atm_acc, accel_trimmed_mean_filter and the testbench; depends on nothing.
package atm_pkg;

  localparam int AVERAGE_COUNT = 8;
  localparam int WIN_LEN       = AVERAGE_COUNT + 2;
  localparam int AVG_SHIFT     = $clog2(AVERAGE_COUNT);
  localparam int OUT_SHIFT     = 6;
  localparam int SAMPLE_W      = 16;
  localparam int SUM_W         = SAMPLE_W + $clog2(WIN_LEN);
  localparam int RES_W         = SAMPLE_W - OUT_SHIFT;
  localparam int RMP_W         = RES_W + 1;
  localparam int SM_W          = 10;
  localparam int PACK_W        = 3 * SM_W;
  localparam int CNT_W         = $clog2(WIN_LEN);
  localparam int MODE_W        = 2;

  typedef logic signed [SAMPLE_W-1:0] samp_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [RES_W-1:0]    res_t;
  typedef logic signed [RMP_W-1:0]    rmp_t;
  typedef logic        [SM_W-1:0]     sm_t;
  typedef logic        [CNT_W-1:0]    cnt_t;
  typedef logic        [MODE_W-1:0]   mode_t;

  localparam sum_t  AVG_BIAS = SUM_W'(AVERAGE_COUNT - 1);
  localparam cnt_t  CNT_LAST = CNT_W'(WIN_LEN - 1);

  localparam mode_t ORIENT_NONE = 2'd0;
  localparam mode_t ORIENT_YZ   = 2'd1;
  localparam mode_t ORIENT_ZY   = 2'd2;

  localparam logic  ACT_FILTER  = 1'b0;
  localparam logic  ACT_RESTART = 1'b1;

  typedef struct packed {
    samp_t x;
    samp_t y;
    samp_t z;
  } xyz_t;

  typedef struct packed {
    logic fill;
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  function automatic sm_t to_sign_mag(input rmp_t v);
    rmp_t mag;
    sm_t  r;
    mag = -v;
    if (v < 0) begin
      r = {1'b1, mag[SM_W-2:0]};
    end else begin
      r = v[SM_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/atm_cell.sv
`timescale 1ns / 1ps
// One window entry of the filter chain, holding an x, y and z sample.
// Depends on atm_pkg for the sample and control types.
module atm_cell (
  input  logic               clk,
  input  atm_pkg::cell_ctrl_t ctrl,
  input  atm_pkg::xyz_t      samp,
  input  atm_pkg::xyz_t      nbr,
  output atm_pkg::xyz_t      q
);

  atm_pkg::xyz_t val_r;
  atm_pkg::xyz_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    priority if (ctrl.fill) begin
      val_nxt = samp;
    end else if (ctrl.shift || ctrl.rotate) begin
      val_nxt = nbr;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

// File: design/atm_acc.sv
`timescale 1ns / 1ps
// Per-axis running sum, minimum and maximum over the rotating window,
// plus the trimmed mean and output scaling. Depends on atm_pkg.
module atm_acc (
  input  logic           clk,
  input  logic           step,
  input  logic           first,
  input  atm_pkg::samp_t value,
  output atm_pkg::res_t  res
);

  atm_pkg::sum_t  sum_r, sum_nxt;
  atm_pkg::samp_t lo_r, lo_nxt;
  atm_pkg::samp_t hi_r, hi_nxt;
  atm_pkg::sum_t  val_ext;
  atm_pkg::sum_t  diff;
  atm_pkg::sum_t  biased;

  assign val_ext = atm_pkg::sum_t'(value);

  always_comb begin
    sum_nxt = sum_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (step) begin
      if (first) begin
        sum_nxt = val_ext;
        lo_nxt  = value;
        hi_nxt  = value;
      end else begin
        sum_nxt = sum_r + val_ext;
        lo_nxt  = (value < lo_r) ? value : lo_r;
        hi_nxt  = (value > hi_r) ? value : hi_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

  // round toward zero on the divide, floor on the output shift
  assign diff   = sum_r - atm_pkg::sum_t'(lo_r) - atm_pkg::sum_t'(hi_r);
  assign biased = diff[atm_pkg::SUM_W-1] ? diff + atm_pkg::AVG_BIAS : diff;
  assign res    = biased[atm_pkg::AVG_SHIFT + atm_pkg::OUT_SHIFT +: atm_pkg::RES_W];

endmodule

// File: design/accel_trimmed_mean_filter.sv
`timescale 1ns / 1ps
// Top level of the accelerometer trimmed-mean filter: cell chain, three
// accumulators, sequencer and output register. Depends on atm_pkg, atm_cell, atm_acc.
//
// Usage:
//   Input channel (in_valid/in_ready) carries in_action and signed 16-bit
//   in_sample_x/y/z. in_action = 0 filters a sample and yields one
//   transaction on the output channel; in_action = 1 restarts (the next
//   sample refills the whole window) and yields nothing.
//   Output channel (out_valid/out_ready) carries out_packed_xyz: three
//   10-bit sign-magnitude groups, x in 29:20, y in 19:10, z in 9:0.
//   cfg_we/cfg_wdata write the orientation mode at any idle cycle.
//   Timing: a sample enters the chain on acceptance, the chain rotates
//   through the whole window (one window entry per cycle into the
//   accumulators), then the DONE state forms and registers the result.
//   in_ready is low from acceptance until the result is registered, so a
//   new sample waits for the window walk. A restart leaves the block idle.
//   A stalled receiver holds the result in the output register; the next
//   sample is accepted meanwhile and its result waits in the final step
//   until the register drains.
//   Reset (rst_n low, synchronous) empties the window, clears out_valid
//   and sets the orientation mode to 0; out_packed_xyz is not reset.
module accel_trimmed_mean_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_sample_x,
  input  logic [15:0] in_sample_y,
  input  logic [15:0] in_sample_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] out_packed_xyz,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  atm_pkg::state_t     state_r, state_nxt;
  atm_pkg::cnt_t       cnt_r, cnt_nxt;
  logic                filled_r, filled_nxt;
  atm_pkg::mode_t      mode_r, mode_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [atm_pkg::PACK_W-1:0] out_data_r, out_data_nxt;

  atm_pkg::cell_ctrl_t ctrl;
  atm_pkg::xyz_t       samp;
  atm_pkg::xyz_t       cell_q [atm_pkg::WIN_LEN];
  atm_pkg::xyz_t       cell_nbr [atm_pkg::WIN_LEN];
  atm_pkg::res_t       res_x, res_y, res_z;
  atm_pkg::rmp_t       fx, fy, fz, ey, ez;
  logic                in_take;
  logic                acc_step;
  logic                load_out;

  assign in_ready = (state_r == atm_pkg::ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign samp     = '{x: in_sample_x, y: in_sample_y, z: in_sample_z};
  assign acc_step = (state_r == atm_pkg::ST_RUN);
  assign load_out = (state_r == atm_pkg::ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    ctrl.fill   = in_take && (in_action == atm_pkg::ACT_FILTER) && !filled_r;
    ctrl.shift  = in_take && (in_action == atm_pkg::ACT_FILTER) && filled_r;
    ctrl.rotate = acc_step;
  end

  genvar gi;
  generate
    for (gi = 0; gi < atm_pkg::WIN_LEN; gi++) begin : g_cell
      if (gi == atm_pkg::WIN_LEN - 1) begin : g_tail
        assign cell_nbr[gi] = ctrl.shift ? samp : cell_q[0];
      end else begin : g_body
        assign cell_nbr[gi] = cell_q[gi+1];
      end
      atm_cell u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .samp (samp),
        .nbr  (cell_nbr[gi]),
        .q    (cell_q[gi])
      );
    end
  endgenerate

  atm_acc u_acc_x (
    .clk(clk), .step(acc_step), .first(cnt_r == '0), .value(cell_q[0].x), .res(res_x)
  );
  atm_acc u_acc_y (
    .clk(clk), .step(acc_step), .first(cnt_r == '0), .value(cell_q[0].y), .res(res_y)
  );
  atm_acc u_acc_z (
    .clk(clk), .step(acc_step), .first(cnt_r == '0), .value(cell_q[0].z), .res(res_z)
  );

  // remap y and z by orientation mode
  always_comb begin
    fx = atm_pkg::rmp_t'(res_x);
    ey = atm_pkg::rmp_t'(res_y);
    ez = atm_pkg::rmp_t'(res_z);
    priority if (mode_r == atm_pkg::ORIENT_ZY) begin
      fy = -ez;
      fz = ey;
    end else if (mode_r != atm_pkg::ORIENT_NONE) begin
      fy = ez;
      fz = -ey;
    end else begin
      fy = ey;
      fz = ez;
    end
  end

  assign out_data_nxt = load_out ?
      {atm_pkg::to_sign_mag(fx), atm_pkg::to_sign_mag(fy), atm_pkg::to_sign_mag(fz)} :
      out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    filled_nxt    = filled_r;
    mode_nxt      = cfg_we ? cfg_wdata : mode_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      atm_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_action == atm_pkg::ACT_RESTART) begin
            filled_nxt = 1'b0;
          end else begin
            filled_nxt = 1'b1;
            cnt_nxt    = '0;
            state_nxt  = atm_pkg::ST_RUN;
          end
        end
      end
      atm_pkg::ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == atm_pkg::CNT_LAST) begin
          state_nxt = atm_pkg::ST_DONE;
        end
      end
      atm_pkg::ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = atm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = atm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atm_pkg::ST_IDLE;
      cnt_r       <= '0;
      filled_r    <= 1'b0;
      mode_r      <= atm_pkg::ORIENT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      filled_r    <= filled_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_packed_xyz = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == atm_pkg::ST_RUN) |-> (cnt_r <= atm_pkg::CNT_LAST))
    else $error("window walk counter out of range");

  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == atm_pkg::ST_RUN) |-> ##(atm_pkg::WIN_LEN) (state_r == atm_pkg::ST_DONE))
    else $error("window walk did not take one cycle per entry");

  a_sample_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_action == atm_pkg::ACT_FILTER) |=>
      (filled_r && state_r == atm_pkg::ST_RUN))
    else $error("sample did not mark window filled");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_action == atm_pkg::ACT_RESTART) |=>
      (!filled_r && state_r == atm_pkg::ST_IDLE))
    else $error("restart did not empty window");

  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == atm_pkg::ST_DONE && out_valid_r && !out_ready) |=>
      (state_r == atm_pkg::ST_DONE && $stable(out_data_r)))
    else $error("pending result overwrote a stalled transaction");

endmodule

// File: tb/atm_filter_checker.sv
`timescale 1ns / 1ps
// Result checker for accel_trimmed_mean_filter: keeps its own copy of the sample windows and
// orientation mode, predicts every packed result and compares it on the output channel.
// Depends on atm_pkg.
module atm_filter_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_action,
  input  atm_pkg::samp_t             in_sample_x,
  input  atm_pkg::samp_t             in_sample_y,
  input  atm_pkg::samp_t             in_sample_z,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [atm_pkg::PACK_W-1:0] out_packed_xyz,
  input  logic                       cfg_we,
  input  atm_pkg::mode_t             cfg_wdata,
  output int                         error_count,
  output int                         results_owed
);

  localparam atm_pkg::sm_t NEG_FLAG = 10'h200;
  localparam int           AX_X     = 0;
  localparam int           AX_Y     = 1;
  localparam int           AX_Z     = 2;

  atm_pkg::samp_t             window [3][atm_pkg::WIN_LEN];
  logic                       primed;
  atm_pkg::mode_t             orient;
  logic [atm_pkg::PACK_W-1:0] expected_words [$];

  function automatic void shift_in(int ax, atm_pkg::samp_t s);
    int i;
    if (!primed) begin
      for (i = 0; i < atm_pkg::WIN_LEN; i++) window[ax][i] = s;
    end else begin
      for (i = 0; i < atm_pkg::WIN_LEN - 1; i++) window[ax][i] = window[ax][i + 1];
      window[ax][atm_pkg::WIN_LEN - 1] = s;
    end
  endfunction

  function automatic int trimmed_avg(int ax);
    int acc, lo, hi, q, i;
    acc = 0;
    lo  = window[ax][0];
    hi  = window[ax][0];
    for (i = 0; i < atm_pkg::WIN_LEN; i++) begin
      acc += window[ax][i];
      if (window[ax][i] < lo) lo = window[ax][i];
      if (window[ax][i] > hi) hi = window[ax][i];
    end
    q = (acc - lo - hi) / atm_pkg::AVERAGE_COUNT;
    return q >>> atm_pkg::OUT_SHIFT;
  endfunction

  function automatic atm_pkg::sm_t encode_axis(int v);
    if (v < 0) return atm_pkg::sm_t'(-v) | NEG_FLAG;
    return atm_pkg::sm_t'(v);
  endfunction

  always @(posedge clk) begin
    logic [atm_pkg::PACK_W-1:0] want;
    int fx, fy, fz, t;
    if (!rst_n) begin
      primed = 1'b0;
      orient = atm_pkg::ORIENT_NONE;
      expected_words.delete();
      error_count  <= 0;
      results_owed <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("packed_xyz: unexpected transaction, actual %h", out_packed_xyz);
          error_count <= error_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (out_packed_xyz !== want) begin
            $error("packed_xyz mismatch: expected %h, actual %h", want, out_packed_xyz);
            error_count <= error_count + 1;
          end
        end
      end
      if (cfg_we) orient = cfg_wdata;
      if (in_valid && in_ready) begin
        if (in_action == atm_pkg::ACT_RESTART) begin
          primed = 1'b0;
        end else begin
          shift_in(AX_X, in_sample_x);
          shift_in(AX_Y, in_sample_y);
          shift_in(AX_Z, in_sample_z);
          primed = 1'b1;
          fx = trimmed_avg(AX_X);
          fy = trimmed_avg(AX_Y);
          fz = trimmed_avg(AX_Z);
          if (orient == atm_pkg::ORIENT_ZY) begin
            t  = fy;
            fy = -fz;
            fz = t;
          end else if (orient != atm_pkg::ORIENT_NONE) begin
            t  = -fy;
            fy = fz;
            fz = t;
          end
          expected_words.push_back({encode_axis(fx), encode_axis(fy), encode_axis(fz)});
        end
      end
      results_owed <= expected_words.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for accel_trimmed_mean_filter: clock, reset, bursty sample stimulus,
// receiver stall patterns and the verdict. Depends on atm_pkg, the block and atm_filter_checker.
module tb;

  localparam atm_pkg::mode_t ORIENT_ALIAS = 2'd3;
  localparam atm_pkg::samp_t S_MAX        = 16'sh7fff;
  localparam atm_pkg::samp_t S_MIN        = 16'sh8000;
  localparam int             CYCLE_LIMIT  = 600000;
  localparam int             SETTLE       = 16;
  localparam int             HOLD_CYCLES  = 400;
  localparam int             PHASES       = 6;
  localparam int             PHASE_ITEMS  = 222;
  localparam int             RX_OPEN      = 0;
  localparam int             RX_COIN      = 1;
  localparam int             RX_SPARSE    = 2;
  localparam int             RX_PERIODIC  = 3;

  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_action      = atm_pkg::ACT_FILTER;
  logic [15:0]                in_sample_x    = '0;
  logic [15:0]                in_sample_y    = '0;
  logic [15:0]                in_sample_z    = '0;
  logic                       out_ready      = 1'b0;
  logic                       cfg_we         = 1'b0;
  logic [1:0]                 cfg_wdata      = atm_pkg::ORIENT_NONE;
  logic                       in_ready;
  logic                       out_valid;
  logic [atm_pkg::PACK_W-1:0] out_packed_xyz;
  int                         error_count;
  int                         results_owed;
  int                         cycles         = 0;
  int                         burst_left     = 0;
  int                         hold_requests  = 0;
  atm_pkg::samp_t             drift [3];

  accel_trimmed_mean_filter u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .in_sample_z    (in_sample_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packed_xyz (out_packed_xyz),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  atm_filter_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .in_sample_z    (in_sample_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packed_xyz (out_packed_xyz),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .error_count    (error_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[accel_trimmed_mean_filter] ERROR");
      $finish;
    end
  end

  // Receiver: switch stall pattern after each randomly drawn span; serve hold requests.
  initial begin
    int style, span, holds_served;
    style        = RX_OPEN;
    span         = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (span == 0) begin
        style = $urandom_range(RX_OPEN, RX_PERIODIC);
        span  = $urandom_range(20, 300);
      end
      span--;
      case (style)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= $urandom_range(0, 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ((cycles % 7) < 3);
      endcase
    end
  end

  function automatic atm_pkg::samp_t pick_sample(atm_pkg::samp_t centre);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1, 2:    return atm_pkg::samp_t'($urandom);
      default: return atm_pkg::samp_t'(int'(centre) + int'($urandom_range(0, 1023)) - 512);
    endcase
  endfunction

  task automatic send_txn(logic act, atm_pkg::samp_t sx, atm_pkg::samp_t sy,
                          atm_pkg::samp_t sz);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 3))
        @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_sample_x <= sx;
    in_sample_y <= sy;
    in_sample_z <= sz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic drain_and_settle();
    if (burst_left != 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_orient(atm_pkg::mode_t m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int             ph, n, a;
    atm_pkg::mode_t m;
    drift[0] = '0;
    drift[1] = '0;
    drift[2] = 16'sd4096;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_orient(atm_pkg::ORIENT_NONE);
    send_txn(atm_pkg::ACT_FILTER, S_MAX, S_MIN, 16'sd0);
    send_txn(atm_pkg::ACT_RESTART, 16'sd0, 16'sd0, 16'sd0);
    send_txn(atm_pkg::ACT_FILTER, S_MIN, S_MAX, -16'sd1);
    send_txn(atm_pkg::ACT_FILTER, 16'sd1234, -16'sd5, S_MAX);
    send_txn(atm_pkg::ACT_FILTER, -16'sd1, 16'sd0, S_MIN);
    send_txn(atm_pkg::ACT_FILTER, 16'sh5555, 16'shaaaa, 16'sd100);
    send_txn(atm_pkg::ACT_RESTART, S_MAX, S_MIN, S_MAX);
    send_txn(atm_pkg::ACT_RESTART, S_MIN, S_MAX, S_MIN);
    send_txn(atm_pkg::ACT_FILTER, 16'sd0, 16'sd0, 16'sd0);
    drain_and_settle();

    write_orient(atm_pkg::ORIENT_YZ);
    send_txn(atm_pkg::ACT_RESTART, 16'sd0, 16'sd0, 16'sd0);
    send_txn(atm_pkg::ACT_FILTER, 16'sd100, S_MIN, S_MAX);
    send_txn(atm_pkg::ACT_FILTER, -16'sd100, S_MAX, S_MIN);
    drain_and_settle();

    write_orient(atm_pkg::ORIENT_ZY);
    send_txn(atm_pkg::ACT_RESTART, 16'sd0, 16'sd0, 16'sd0);
    send_txn(atm_pkg::ACT_FILTER, S_MIN, 16'sd5000, S_MIN);
    send_txn(atm_pkg::ACT_FILTER, S_MAX, -16'sd5000, S_MAX);
    drain_and_settle();

    write_orient(ORIENT_ALIAS);
    send_txn(atm_pkg::ACT_RESTART, 16'sd0, 16'sd0, 16'sd0);
    send_txn(atm_pkg::ACT_FILTER, 16'sd0, S_MIN, S_MAX);
    send_txn(atm_pkg::ACT_FILTER, 16'sd511, 16'sd512, -16'sd513);
    drain_and_settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       m = atm_pkg::ORIENT_YZ;
        1:       m = atm_pkg::ORIENT_NONE;
        2:       m = atm_pkg::ORIENT_ZY;
        3:       m = ORIENT_ALIAS;
        4:       m = atm_pkg::ORIENT_ZY;
        default: m = atm_pkg::ORIENT_NONE;
      endcase
      write_orient(m);
      // Block the receiver while samples keep coming so the pipeline backs up.
      if (ph == 0) hold_requests++;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        for (a = 0; a < 3; a++) begin
          if ($urandom_range(0, 49) == 0) drift[a] = atm_pkg::samp_t'($urandom);
          else drift[a] = atm_pkg::samp_t'(int'(drift[a]) + int'($urandom_range(0, 255)) - 128);
        end
        if ($urandom_range(0, 24) == 0) begin
          send_txn(atm_pkg::ACT_RESTART, atm_pkg::samp_t'($urandom),
                   atm_pkg::samp_t'($urandom), atm_pkg::samp_t'($urandom));
        end else begin
          send_txn(atm_pkg::ACT_FILTER, pick_sample(drift[0]), pick_sample(drift[1]),
                   pick_sample(drift[2]));
        end
      end
      drain_and_settle();
    end

    if (error_count == 0 && results_owed == 0) begin
      $display("[accel_trimmed_mean_filter] OK");
    end else begin
      $display("[accel_trimmed_mean_filter] ERROR");
    end
    $finish;
  end

endmodule

// File: accel_trimmed_mean_filter.f
design/atm_pkg.sv
design/atm_cell.sv
design/atm_acc.sv
design/accel_trimmed_mean_filter.sv
tb/atm_filter_checker.sv
tb/tb.sv
